/* rtl/core/rhsp_pkg.sv */
`timescale 1ns / 1ps

package rhsp_pkg;

    // Channel conversion constants
    localparam int CH_MIN  = 172;
    localparam int CH_MID  = 992;
    localparam int CH_SPAN = 1639;

    // Pulse width window and scaling: s = (x - 1000) * 8 / 5 + 192
    localparam int US_MIN       = 1000;
    localparam int US_MAX       = 2000;
    localparam int SCALE_SHIFT  = 15;
    localparam int SCALE_RECIP5 = (2 ** SCALE_SHIFT) / 5 + 1;
    localparam int SCALE_MUL    = 8 * SCALE_RECIP5;
    localparam int SCALE_OFFSET = 192;

    // Position conversion: floor(off * cnt / (SPAN + 1)) by reciprocal
    localparam int POS_SHIFT = 26;
    localparam int POS_RECIP = (2 ** POS_SHIFT) / (CH_SPAN + 1) + 1;
    localparam int POS_MUL6  = 6 * POS_RECIP;
    localparam int POS_MUL16 = 16 * POS_RECIP;

    // Six-position centre window
    localparam int SIX_Q       = (CH_SPAN / 6) / 4;
    localparam int SIX_LO      = CH_MID - SIX_Q;
    localparam int SIX_HI      = CH_MID + SIX_Q;
    localparam int CENTRE_CODE = 7;

    localparam int NUM_LANES = 8;
    localparam int NUM_SW    = 7;

    // Configuration register indexes
    localparam logic [0:0] REG_DEFAULT_AUX = 1'd0;
    localparam logic [0:0] REG_PACKET_TYPE = 1'd1;

    localparam logic [10:0] DEFAULT_AUX_RESET = 11'd992;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_POS,
        ST_SEL
    } state_t;

    // One outgoing word
    typedef struct packed {
        logic [1:0] type_byte;
        logic [7:0] aileron_high;
        logic [7:0] elevator_high;
        logic [7:0] throttle_high;
        logic [7:0] rudder_high;
        logic [7:0] low_bits_byte;
        logic [7:0] switch_byte;
    } result_t;

endpackage

/* rtl/core/rhsp_lane.sv */
`timescale 1ns / 1ps

module rhsp_lane
    import rhsp_pkg::*;
(
    input  logic        aclk,
    input  logic        load_en,
    input  logic [10:0] us_in,
    output logic [10:0] scaled
);

    logic [10:0] clamped;
    logic [9:0]  delta;
    logic [25:0] prod;
    logic [10:0] scaled_reg;
    logic [10:0] scaled_next;

    // Clamp to 1000..2000 us, then scale by 8/5 via reciprocal
    always_comb begin
        if (us_in < 11'(US_MIN)) begin
            clamped = 11'(US_MIN);
        end else if (us_in > 11'(US_MAX)) begin
            clamped = 11'(US_MAX);
        end else begin
            clamped = us_in;
        end
        delta       = 10'(clamped - 11'(US_MIN));
        prod        = 26'(delta) * 26'(SCALE_MUL);
        scaled_next = 11'(prod >> SCALE_SHIFT) + 11'(SCALE_OFFSET);
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

/* rtl/core/rhsp_pos.sv */
`timescale 1ns / 1ps

module rhsp_pos
    import rhsp_pkg::*;
(
    input  logic        aclk,
    input  logic        load_en,
    input  logic        is_16,
    input  logic [10:0] value,
    output logic [3:0]  position
);

    logic [10:0] offset;
    logic [19:0] mul_k;
    logic [30:0] prod_reg;
    logic [30:0] prod_next;
    logic        below_reg;
    logic        below_next;
    logic        centre_reg;
    logic        centre_next;

    // Window checks and reciprocal multiply
    always_comb begin
        below_next  = value < 11'(CH_MIN);
        centre_next = !is_16 && (value >= 11'(SIX_LO)) && (value <= 11'(SIX_HI));
        offset      = below_next ? 11'd0 : 11'(value - 11'(CH_MIN));
        mul_k       = is_16 ? 20'(POS_MUL16) : 20'(POS_MUL6);
        prod_next   = 31'(offset) * 31'(mul_k);
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            prod_reg   <= prod_next;
            below_reg  <= below_next;
            centre_reg <= centre_next;
        end
    end

    // Six-position values never exceed 7 (the centre code), so four bits hold both kinds
    always_comb begin
        if (below_reg) begin
            position = 4'd0;
        end else if (centre_reg) begin
            position = 4'(CENTRE_CODE);
        end else begin
            position = 4'(prod_reg >> POS_SHIFT);
        end
    end

endmodule

/* rtl/core/rhsp_merge.sv */
`timescale 1ns / 1ps

module rhsp_merge
    import rhsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        commit,
    output logic        out_free,
    input  logic [10:0] stick [4],
    input  logic        arm,
    input  logic [3:0]  cur [NUM_SW],
    input  logic [1:0]  packet_type,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_word
);

    logic [3:0] sent_reg [NUM_SW];
    logic [2:0] rr_reg;
    logic [2:0] rr_next;
    logic       valid_reg;
    result_t    word_reg;
    result_t    word_next;
    logic [2:0] sel;
    logic [2:0] sel_idx;
    logic [3:0] val;
    logic       found;

    assign out_free = !valid_reg || m_ready;

    // First changed switch, otherwise round robin
    always_comb begin
        found = 1'b0;
        sel   = rr_reg;
        for (int i = 0; i < NUM_SW; i++) begin
            if (!found && (cur[i] != sent_reg[i])) begin
                found = 1'b1;
                sel   = 3'(i + 1);
            end
        end
        sel_idx = 3'(sel - 3'd1);
        val     = cur[sel_idx];
        rr_next = (sel == 3'(NUM_SW)) ? 3'd1 : 3'(sel + 3'd1);
    end

    // Assemble the outgoing word
    always_comb begin
        word_next.type_byte     = packet_type;
        word_next.aileron_high  = stick[0][10:3];
        word_next.elevator_high = stick[1][10:3];
        word_next.throttle_high = stick[2][10:3];
        word_next.rudder_high   = stick[3][10:3];
        word_next.low_bits_byte = {stick[0][2:1], stick[1][2:1],
                                   stick[2][2:1], stick[3][2:1]};
        word_next.switch_byte   = {1'b0, arm, 6'd0} | {2'd0, sel_idx, 3'd0} | {4'd0, val};
    end

    // Switch history and pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SW; i++) begin
                sent_reg[i] <= 4'd0;
            end
            rr_reg <= 3'd1;
        end else if (commit) begin
            sent_reg[sel_idx] <= val;
            rr_reg            <= rr_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (commit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            word_reg <= word_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

endmodule

/* rtl/core/rc_hybrid_switch_packer_core.sv */
`timescale 1ns / 1ps

// RC channel packer with hybrid switch encoding.
// Input channel (s_valid/s_ready): one word of eight pulse widths in us,
// four sticks and four aux channels. Result channel (m_valid/m_ready):
// one packed word per input word: packet type, four stick high bytes,
// a byte of stick low bits and one switch byte.
// Configuration: cfg_wr_en with cfg_wr_index 0 sets the default aux value,
// index 1 the packet type; write only while no word is in flight.
// Path from input acceptance to m_valid: eight scaling
// lanes, position multipliers, switch selection into the output
// register. No new word is taken until the last has left selection;
// the three steps run the lanes and five position units in turn.
// A finished word waits in the output register while the next input is
// taken; if the receiver still stalls at selection time, the block holds
// in selection and s_ready stays low until the register frees.
// Reset (aresetn low, synchronous) clears the switch history, sets the
// round robin pointer to switch 1 and restores the register defaults.

module rc_hybrid_switch_packer_core
    import rhsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_wr_index,
    input  logic [10:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [10:0] s_aileron_us,
    input  logic [10:0] s_elevator_us,
    input  logic [10:0] s_throttle_us,
    input  logic [10:0] s_rudder_us,
    input  logic [10:0] s_aux1_us,
    input  logic [10:0] s_aux2_us,
    input  logic [10:0] s_aux3_us,
    input  logic [10:0] s_aux4_us,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_type_byte,
    output logic [7:0]  m_aileron_high,
    output logic [7:0]  m_elevator_high,
    output logic [7:0]  m_throttle_high,
    output logic [7:0]  m_rudder_high,
    output logic [7:0]  m_low_bits_byte,
    output logic [7:0]  m_switch_byte
);

    state_t      state_reg;
    state_t      state_next;
    logic [10:0] default_aux_reg;
    logic [1:0]  packet_type_reg;
    logic [10:0] us_in  [NUM_LANES];
    logic [10:0] us_reg [NUM_LANES];
    logic [10:0] scaled [NUM_LANES];
    logic [10:0] stick  [4];
    logic [3:0]  cur    [NUM_SW];
    logic [3:0]  pos_default6;
    logic        arm;
    logic        accept;
    logic        scale_en;
    logic        pos_en;
    logic        commit;
    logic        out_free;
    result_t     m_word;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_aux_reg <= DEFAULT_AUX_RESET;
            packet_type_reg <= 2'd0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_DEFAULT_AUX: default_aux_reg <= cfg_wr_data;
                REG_PACKET_TYPE: packet_type_reg <= cfg_wr_data[1:0];
                default:         default_aux_reg <= default_aux_reg;
            endcase
        end
    end

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_POS;
            ST_POS:   state_next = ST_SEL;
            ST_SEL:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_ready  = 1'b0;
        scale_en = 1'b0;
        pos_en   = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE:  s_ready  = 1'b1;
            ST_SCALE: scale_en = 1'b1;
            ST_POS:   pos_en   = 1'b1;
            ST_SEL:   commit   = out_free;
            default:  s_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign accept = s_valid && s_ready;

    // Input capture
    assign us_in[0] = s_aileron_us;
    assign us_in[1] = s_elevator_us;
    assign us_in[2] = s_throttle_us;
    assign us_in[3] = s_rudder_us;
    assign us_in[4] = s_aux1_us;
    assign us_in[5] = s_aux2_us;
    assign us_in[6] = s_aux3_us;
    assign us_in[7] = s_aux4_us;

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                us_reg[i] <= us_in[i];
            end
        end
    end

    // Scaling lanes
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rhsp_lane u_lane (
            .aclk    (aclk),
            .load_en (scale_en),
            .us_in   (us_reg[g]),
            .scaled  (scaled[g])
        );
    end

    // Position units: aux2..aux4 for switches 1..3
    for (genvar g = 0; g < 3; g++) begin : g_pos_aux
        rhsp_pos u_pos (
            .aclk     (aclk),
            .load_en  (pos_en),
            .is_16    (1'b0),
            .value    (scaled[5 + g]),
            .position (cur[g])
        );
    end

    // Default value, six positions for switches 4..6
    rhsp_pos u_pos_def6 (
        .aclk     (aclk),
        .load_en  (pos_en),
        .is_16    (1'b0),
        .value    (default_aux_reg),
        .position (pos_default6)
    );

    // Default value, sixteen positions for switch 7
    rhsp_pos u_pos_def16 (
        .aclk     (aclk),
        .load_en  (pos_en),
        .is_16    (1'b1),
        .value    (default_aux_reg),
        .position (cur[6])
    );

    assign cur[3] = pos_default6;
    assign cur[4] = pos_default6;
    assign cur[5] = pos_default6;

    assign stick[0] = scaled[0];
    assign stick[1] = scaled[1];
    assign stick[2] = scaled[2];
    assign stick[3] = scaled[3];
    assign arm      = scaled[4] > 11'(CH_MID);

    // Switch selection and output register
    rhsp_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .commit      (commit),
        .out_free    (out_free),
        .stick       (stick),
        .arm         (arm),
        .cur         (cur),
        .packet_type (packet_type_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word)
    );

    assign m_type_byte     = m_word.type_byte;
    assign m_aileron_high  = m_word.aileron_high;
    assign m_elevator_high = m_word.elevator_high;
    assign m_throttle_high = m_word.throttle_high;
    assign m_rudder_high   = m_word.rudder_high;
    assign m_low_bits_byte = m_word.low_bits_byte;
    assign m_switch_byte   = m_word.switch_byte;

endmodule
